FILE: src/lzsd_pkg.sv
// Shared types and constants for the LZ77 stream decompressor.
// Used by the controller, the datapath and the top level; no dependencies.
package lzsd_pkg;

   localparam int BYTE_W    = 8;
   localparam int SIZE_W    = 24;
   localparam int DIST_W    = 12;
   localparam int LEN_W     = 5;
   localparam int FLAG_CNT_W = 4;
   localparam logic [LEN_W-1:0]      LEN_BIAS   = 5'd3;
   localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE = 4'd8;

   // Position in the compressed stream syntax
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_FLAG,
      PH_DATA,
      PH_TOKLO
   } phase_type;

   // Controller sequencing state
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_ACCEPT,
      ST_LIT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_CONSUME
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       stream_start;
      logic [2:0] hdr_lane;
      logic       flag_load;
      logic       tok_load;
      logic       lit_load;
      logic       copy_setup;
      logic       rd_issue;
      logic       emit_lit;
      logic       emit_copy;
      logic       consume;
      logic       clear_step;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic flag_msb;
      logic size_hit;
      logic flags_last;
      logic hdr_zero;
      logic copy_done;
      logic out_free;
   } status_type;

endpackage

FILE: src/lzsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lzsd_ctrl.sv
// Controller of the LZ77 stream decompressor: stream parser and sequencer.
// Depends on lzsd_pkg for the phase, state, command and status types.
module lzsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_start,
   input  lzsd_pkg::status_type status,
   output lzsd_pkg::cmd_type    cmd,
   output logic                req_tready
);

   lzsd_pkg::state_type state_ff, state_in;
   lzsd_pkg::phase_type phase_ff, phase_in;
   logic                xfer;

   assign xfer = req_tvalid && (state_ff == lzsd_pkg::ST_ACCEPT);

   // Hold state and parse phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzsd_pkg::ST_CLEAR;
         phase_ff <= lzsd_pkg::PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // Next state and next parse phase
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         lzsd_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = lzsd_pkg::ST_ACCEPT;
            end
         end
         lzsd_pkg::ST_ACCEPT: begin
            if (xfer) begin
               if (req_start) begin
                  phase_in = lzsd_pkg::PH_HDR1;
               end else begin
                  case (phase_ff)
                     lzsd_pkg::PH_HDR1: phase_in = lzsd_pkg::PH_HDR2;
                     lzsd_pkg::PH_HDR2: phase_in = lzsd_pkg::PH_HDR3;
                     lzsd_pkg::PH_HDR3: begin
                        phase_in = status.hdr_zero ? lzsd_pkg::PH_IDLE : lzsd_pkg::PH_FLAG;
                     end
                     lzsd_pkg::PH_FLAG: phase_in = lzsd_pkg::PH_DATA;
                     lzsd_pkg::PH_DATA: begin
                        if (status.flag_msb) begin
                           phase_in = lzsd_pkg::PH_TOKLO;
                        end else begin
                           state_in = lzsd_pkg::ST_LIT;
                        end
                     end
                     lzsd_pkg::PH_TOKLO: state_in = lzsd_pkg::ST_COPY_RD;
                     default: phase_in = lzsd_pkg::PH_IDLE;
                  endcase
               end
            end
         end
         lzsd_pkg::ST_LIT: begin
            if (status.out_free) begin
               state_in = lzsd_pkg::ST_CONSUME;
            end
         end
         lzsd_pkg::ST_COPY_RD: begin
            if (status.copy_done || status.size_hit) begin
               state_in = lzsd_pkg::ST_CONSUME;
            end else begin
               state_in = lzsd_pkg::ST_COPY_WR;
            end
         end
         lzsd_pkg::ST_COPY_WR: begin
            if (status.out_free) begin
               state_in = lzsd_pkg::ST_COPY_RD;
            end
         end
         lzsd_pkg::ST_CONSUME: begin
            state_in = lzsd_pkg::ST_ACCEPT;
            if (status.size_hit) begin
               phase_in = lzsd_pkg::PH_IDLE;
            end else if (status.flags_last) begin
               phase_in = lzsd_pkg::PH_FLAG;
            end else begin
               phase_in = lzsd_pkg::PH_DATA;
            end
         end
         default: state_in = lzsd_pkg::ST_CLEAR;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lzsd_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         lzsd_pkg::ST_ACCEPT: begin
            req_tready = 1'b1;
            if (xfer) begin
               if (req_start) begin
                  cmd.stream_start = 1'b1;
               end else begin
                  case (phase_ff)
                     lzsd_pkg::PH_HDR1: cmd.hdr_lane = 3'b001;
                     lzsd_pkg::PH_HDR2: cmd.hdr_lane = 3'b010;
                     lzsd_pkg::PH_HDR3: cmd.hdr_lane = 3'b100;
                     lzsd_pkg::PH_FLAG: cmd.flag_load = 1'b1;
                     lzsd_pkg::PH_DATA: begin
                        cmd.tok_load = status.flag_msb;
                        cmd.lit_load = !status.flag_msb;
                     end
                     lzsd_pkg::PH_TOKLO: cmd.copy_setup = 1'b1;
                     default: cmd = '0;
                  endcase
               end
            end
         end
         lzsd_pkg::ST_LIT: cmd.emit_lit = status.out_free;
         lzsd_pkg::ST_COPY_RD: cmd.rd_issue = !(status.copy_done || status.size_hit);
         lzsd_pkg::ST_COPY_WR: cmd.emit_copy = status.out_free;
         lzsd_pkg::ST_CONSUME: cmd.consume = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: src/lzsd_datapath.sv
// Datapath of the LZ77 stream decompressor: header, flag and copy registers,
// history window and result register. Depends on lzsd_pkg and lzsd_ram.
module lzsd_datapath #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  lzsd_pkg::cmd_type    cmd,
   input  logic [7:0]          req_tdata,
   input  logic                rsp_tready,
   output lzsd_pkg::status_type status,
   output logic                rsp_tvalid,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [AW-1:0]                     wp_ff, wp_in;
   logic [AW-1:0]                     src_ff, src_in;
   logic [AW-1:0]                     clr_ff, clr_in;
   logic [lzsd_pkg::SIZE_W-1:0]       produced_ff, produced_in;
   logic [lzsd_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [lzsd_pkg::BYTE_W-1:0]       flag_ff, flag_in;
   logic [lzsd_pkg::FLAG_CNT_W-1:0]   fcnt_ff, fcnt_in;
   logic [lzsd_pkg::BYTE_W-1:0]       tok_ff, tok_in;
   logic [lzsd_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic [lzsd_pkg::LEN_W-1:0]        left_ff, left_in;
   logic                              ovalid_ff, ovalid_in;
   logic [lzsd_pkg::BYTE_W-1:0]       odata_ff, odata_in;
   logic                              olast_ff, olast_in;
   logic                              oend_ff, oend_in;

   logic                              emit;
   logic [lzsd_pkg::BYTE_W-1:0]       emit_byte;
   logic [lzsd_pkg::SIZE_W-1:0]       produced_inc;
   logic                              emit_end;
   logic [lzsd_pkg::DIST_W-1:0]       dist_field;
   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [lzsd_pkg::BYTE_W-1:0]       ram_wdata;
   logic [lzsd_pkg::BYTE_W-1:0]       ram_rdata;

   // History window
   lzsd_ram #(
      .WIDTH (lzsd_pkg::BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_issue),
      .rd_addr (src_ff),
      .rd_data (ram_rdata)
   );

   // Pick the byte going out and its end-of-data mark
   assign emit         = cmd.emit_lit || cmd.emit_copy;
   assign emit_byte    = cmd.emit_lit ? byte_ff : ram_rdata;
   assign produced_inc = produced_ff + 1'b1;
   assign emit_end     = (produced_inc == size_ff);
   assign dist_field   = {tok_ff[3:0], req_tdata};

   // Window write port: clearing sweep or emitted byte
   assign ram_we    = cmd.clear_step || emit;
   assign ram_waddr = cmd.clear_step ? clr_ff : wp_ff;
   assign ram_wdata = cmd.clear_step ? '0 : emit_byte;

   // Next values of the parse and copy registers
   always_comb begin
      wp_in       = wp_ff;
      src_in      = src_ff;
      clr_in      = clr_ff;
      produced_in = produced_ff;
      size_in     = size_ff;
      flag_in     = flag_ff;
      fcnt_in     = fcnt_ff;
      tok_in      = tok_ff;
      byte_in     = byte_ff;
      left_in     = left_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.stream_start) begin
         produced_in = '0;
         size_in     = '0;
         flag_in     = '0;
         fcnt_in     = '0;
         tok_in      = '0;
      end
      if (cmd.hdr_lane[0]) size_in[7:0]   = req_tdata;
      if (cmd.hdr_lane[1]) size_in[15:8]  = req_tdata;
      if (cmd.hdr_lane[2]) size_in[23:16] = req_tdata;
      if (cmd.flag_load) begin
         flag_in = req_tdata;
         fcnt_in = lzsd_pkg::FLAGS_PER_BYTE;
      end
      if (cmd.tok_load) tok_in = req_tdata;
      if (cmd.lit_load) byte_in = req_tdata;
      if (cmd.copy_setup) begin
         left_in = {1'b0, tok_ff[7:4]} + lzsd_pkg::LEN_BIAS;
         src_in  = wp_ff - AW'(dist_field) - 1'b1;
      end
      if (cmd.rd_issue) src_in = src_ff + 1'b1;
      if (emit) begin
         wp_in       = wp_ff + 1'b1;
         produced_in = produced_inc;
      end
      if (cmd.emit_copy) left_in = left_ff - 1'b1;
      if (cmd.consume) begin
         flag_in = {flag_ff[6:0], 1'b0};
         fcnt_in = fcnt_ff - 1'b1;
      end
   end

   // Result register: load on emit, drop on transfer
   always_comb begin
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      oend_in   = oend_ff;
      if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
      if (emit) begin
         ovalid_in = 1'b1;
         odata_in  = emit_byte;
         oend_in   = emit_end;
         olast_in  = cmd.emit_lit || (left_ff == lzsd_pkg::LEN_W'(1)) || emit_end;
      end
   end

   // Hold control and stream registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         clr_ff      <= '0;
         produced_ff <= '0;
         size_ff     <= '0;
         flag_ff     <= '0;
         fcnt_ff     <= '0;
         tok_ff      <= '0;
         left_ff     <= '0;
         ovalid_ff   <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         clr_ff      <= clr_in;
         produced_ff <= produced_in;
         size_ff     <= size_in;
         flag_ff     <= flag_in;
         fcnt_ff     <= fcnt_in;
         tok_ff      <= tok_in;
         left_ff     <= left_in;
         ovalid_ff   <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      byte_ff  <= byte_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      oend_ff  <= oend_in;
   end

   // Status toward the controller
   assign status.clear_last = cmd.clear_step && (&clr_ff);
   assign status.flag_msb   = flag_ff[7];
   assign status.size_hit   = (produced_ff == size_ff);
   assign status.flags_last = (fcnt_ff == lzsd_pkg::FLAG_CNT_W'(1));
   assign status.hdr_zero   = (req_tdata == '0) && (size_ff[15:0] == '0);
   assign status.copy_done  = (left_ff == '0);
   assign status.out_free   = !ovalid_ff || rsp_tready;

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = oend_ff;

endmodule

FILE: src/lz77_stream_decompressor.sv
// Top level of the LZ77 stream decompressor.
// Depends on lzsd_pkg, lzsd_ctrl, lzsd_datapath (and lzsd_ram through it).
//
// Usage:
//   req channel carries the compressed stream one byte per transfer; tuser
//   marks a start byte whose data is dropped; it restarts the parser.
//   rsp channel carries decompressed bytes; tlast marks the last byte caused
//   by one input byte, tuser marks the byte that completes the header size.
// Timing:
//   After reset the 4096-byte history window is cleared, one entry a cycle;
//   req_tready stays low until the whole window has been cleared.
//   Header, flag and token-high bytes take only the accept state; a literal
//   also the emit and consume states. A back-reference token low byte copies
//   len bytes (len 3..18); the window RAM read is registered, so each byte
//   takes a read state, then a write/emit state, and a distance of one reads
//   the byte written just before. A copy cut short by the size ends early.
//   A result waits in one output register; while it waits, the block keeps
//   accepting bytes that produce no output and stalls only on its next emit.
//   A synchronous reset drops any pending result and aborts the stream.
module lz77_stream_decompressor #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] start_req
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] end_of_data
);

   lzsd_pkg::cmd_type    cmd;
   lzsd_pkg::status_type status;

   // Parser and sequencer
   lzsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_start  (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   // Registers, window and result stage
   lzsd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The byte that completes the stream always ends its run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end of data without last of run");

   // The window is being cleared right after reset, so no input is taken
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("input accepted during window clear");

   // Results are loaded only in cycles that do not accept input
   a_emit_not_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result loaded while accepting input");

endmodule
